FILE: rtl/core/scc_pkg.sv
// Shared types, constants and fixed-point helpers for the Coriolis precession term block
package scc_pkg;
	localparam int DataW   = 32;
	localparam int AngleW  = 16;
	localparam int ProdW   = 2 * DataW;
	localparam int CordW   = 34;
	localparam int CordicN = 30;
	localparam int CfgIdxW = 3;
	localparam int InW     = 2 * AngleW + 3 * DataW;

	localparam logic [CfgIdxW-1:0] REG_COMP       = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SCALE      = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_CORIOLIS   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PRECESSION = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_TILT       = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PHASE      = 3'd5;

	localparam logic [1:0] COMP_RADIAL = 2'd0;
	localparam logic [1:0] COMP_COLAT  = 2'd1;
	localparam logic [1:0] COMP_LONG   = 2'd2;

	typedef logic signed [DataW-1:0] data_t;
	typedef logic [AngleW-1:0]       angle_t;
	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic signed [CordW-1:0] cord_t;

	typedef struct packed {
		data_t val;
		logic  clip;
	} rs_t;

	typedef struct packed {
		data_t vr;
		data_t vt;
		data_t vp;
	} vel_t;

	typedef struct packed {
		data_t st;
		data_t ct;
		data_t ss;
		data_t cs;
	} trig_t;

	localparam data_t DataMax    = {1'b0, {(DataW-1){1'b1}}};
	localparam data_t DataMin    = {1'b1, {(DataW-1){1'b0}}};
	localparam data_t TrigOne    = data_t'(32'sd1073741824);
	localparam cord_t TrigOneC   = cord_t'(34'sd1073741824);
	localparam cord_t CordicGain = cord_t'(34'sd652032874);
	localparam data_t ScaleReset = data_t'(32'sd65536);

	localparam logic [ProdW-1:0] MaxPos  = ProdW'(DataMax);
	localparam logic [ProdW-1:0] MaxNeg  = MaxPos + ProdW'(1);
	localparam logic [ProdW-1:0] HalfQ30 = ProdW'(64'd1 << 29);
	localparam logic [ProdW-1:0] HalfQ16 = ProdW'(64'd1 << 15);

	localparam logic [31:0] AtanTurn [CordicN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	// Scale a product down by 2^-30 or 2^-16, round half away from zero, clip
	function automatic rs_t round_sat(input prod_t p, input logic sh30);
		logic             neg;
		logic [ProdW-1:0] mag;
		logic [ProdW-1:0] rnd;
		rs_t              r;
		neg = p[ProdW-1];
		mag = neg ? ProdW'(-p) : ProdW'(p);
		rnd = sh30 ? ((mag + HalfQ30) >> 30) : ((mag + HalfQ16) >> 16);
		r.clip = 1'b0;
		if (!neg) begin
			if (rnd > MaxPos) begin
				r.clip = 1'b1;
				r.val  = DataMax;
			end else begin
				r.val = data_t'(rnd[DataW-1:0]);
			end
		end else if (rnd > MaxNeg) begin
			r.clip = 1'b1;
			r.val  = DataMin;
		end else begin
			r.val = data_t'(~rnd[DataW-1:0] + 1'b1);
		end
		return r;
	endfunction

	function automatic rs_t sat_sum(input data_t a, input data_t b, input logic sub);
		logic signed [DataW:0] s;
		rs_t                   r;
		s = sub ? ((DataW+1)'(a) - (DataW+1)'(b)) : ((DataW+1)'(a) + (DataW+1)'(b));
		r.clip = s[DataW] != s[DataW-1];
		r.val  = r.clip ? (s[DataW] ? DataMin : DataMax) : data_t'(s[DataW-1:0]);
		return r;
	endfunction
endpackage

FILE: rtl/core/spherical_coriolis_precession_term.sv
// Top level of the spherical Coriolis-plus-precession term pipeline
//
// Stream in one grid point per transfer on the s_ group: colatitude, longitude and
// the three velocity components. Stream out one result per point on the m_ group:
// the selected term component in m_tdata and the clip flag in m_tuser.
// Write the six registers through cfg_we/cfg_index/cfg_data while no point is in
// flight; indexes six and seven are ignored.
// Throughput: one point per clock cycle, sustained while m_tready stays high.
// The path from the input transfer to m_tvalid runs through the input register, the
// 30-stage CORDIC plus its quadrant stage, five coefficient stages, six product
// stages and four accumulation stages.
// Reset: registers take their defaults (radial, scale 1.0, all else zero) and the
// pipeline empties; s_tready is high straight after reset.
// Receiver stall: the result is held in the output register and a second one in a
// skid register; s_tready drops only once both are full and the pipeline freezes
// in place, so nothing is lost or repeated.
module spherical_coriolis_precession_term (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// colatitude, longitude, velocity_r, velocity_theta, velocity_phi
	input  logic [scc_pkg::InW-1:0]       s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// force_value
	output logic [scc_pkg::DataW-1:0]     m_tdata,
	// saturated
	output logic                          m_tuser,
	input  logic                          cfg_we,
	input  logic [scc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [scc_pkg::DataW-1:0]     cfg_data
);
	import scc_pkg::*;

	localparam int TrigStage = CordicN + 1;
	localparam int CoefStage = TrigStage + 5;
	localparam int TermStage = CoefStage + 6;
	localparam int LastStage = TermStage + 4;

	logic [1:0] comp_q;
	data_t      scale_q;
	data_t      cor_q;
	data_t      pre_q;
	angle_t     tilt_q;
	angle_t     phase_q;

	logic       en;
	logic       v_s [LastStage+1];
	angle_t     theta_s0;
	angle_t     sph_s0;
	vel_t       vel_s [CoefStage+1];
	trig_t      trig_c;
	trig_t      trig_s [TrigStage+1:CoefStage];
	logic       kclip_s [CoefStage:TermStage];

	data_t      sa;
	data_t      ca;
	data_t      ka;
	data_t      kb;
	logic       kclip;
	data_t      tk  [4];
	data_t      tt1 [4];
	data_t      tt2 [4];
	data_t      tv  [4];
	rs_t        terms [4];
	rs_t        res;
	trig_t      tr;
	vel_t       vl;

	rs_t        out_q;
	rs_t        skid_q;
	logic       ov_q;
	logic       sv_q;
	logic       from_skid;
	logic       from_pipe;
	logic       to_skid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q  <= COMP_RADIAL;
			scale_q <= ScaleReset;
			cor_q   <= '0;
			pre_q   <= '0;
			tilt_q  <= '0;
			phase_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COMP:       comp_q  <= cfg_data[1:0];
				REG_SCALE:      scale_q <= data_t'(cfg_data);
				REG_CORIOLIS:   cor_q   <= data_t'(cfg_data);
				REG_PRECESSION: pre_q   <= data_t'(cfg_data);
				REG_TILT:       tilt_q  <= cfg_data[AngleW-1:0];
				REG_PHASE:      phase_q <= cfg_data[AngleW-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !sv_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LastStage; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= s_tvalid;
			for (int k = 1; k <= LastStage; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			theta_s0 <= s_tdata[AngleW-1:0];
			sph_s0   <= s_tdata[2*AngleW-1:AngleW] + phase_q;
			vel_s[0] <= '{vr: data_t'(s_tdata[2*AngleW+DataW-1:2*AngleW]),
			              vt: data_t'(s_tdata[2*AngleW+2*DataW-1:2*AngleW+DataW]),
			              vp: data_t'(s_tdata[2*AngleW+3*DataW-1:2*AngleW+2*DataW])};
			for (int k = 1; k <= CoefStage; k++) vel_s[k] <= vel_s[k-1];
			trig_s[TrigStage+1] <= trig_c;
			for (int k = TrigStage + 2; k <= CoefStage; k++) trig_s[k] <= trig_s[k-1];
			kclip_s[CoefStage] <= kclip;
			for (int k = CoefStage + 1; k <= TermStage; k++) kclip_s[k] <= kclip_s[k-1];
		end
	end

	scc_cordic u_cordic_alpha (.clk(clk), .en(en), .angle(tilt_q), .sin_v(sa), .cos_v(ca));
	scc_cordic u_cordic_theta (
		.clk(clk), .en(en), .angle(theta_s0),
		.sin_v(trig_c.st), .cos_v(trig_c.ct)
	);
	scc_cordic u_cordic_phase (
		.clk(clk), .en(en), .angle(sph_s0),
		.sin_v(trig_c.ss), .cos_v(trig_c.cs)
	);

	scc_coeff u_coeff (
		.clk(clk), .en(en), .sa(sa), .ca(ca), .scale(scale_q), .cor(cor_q), .pre(pre_q),
		.ka(ka), .kb(kb), .kclip(kclip)
	);

	assign tr = trig_s[CoefStage];
	assign vl = vel_s[CoefStage];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			tk[j]  = '0;
			tt1[j] = '0;
			tt2[j] = TrigOne;
			tv[j]  = '0;
		end
		unique case (comp_q)
			COMP_RADIAL: begin
				tk[0] = ka; tt1[0] = tr.ct; tt2[0] = tr.cs; tv[0] = vl.vp;
				tk[1] = kb; tt1[1] = tr.st; tv[1] = vl.vp;
				tk[2] = ka; tt1[2] = tr.ss; tv[2] = vl.vt;
			end
			COMP_COLAT: begin
				tk[0] = kb; tt1[0] = tr.ct; tv[0] = vl.vp;
				tk[1] = ka; tt1[1] = tr.st; tt2[1] = tr.cs; tv[1] = vl.vp;
				tk[2] = ka; tt1[2] = tr.ss; tv[2] = vl.vr;
			end
			COMP_LONG: begin
				tk[0] = kb; tt1[0] = tr.ct; tv[0] = vl.vt;
				tk[1] = ka; tt1[1] = tr.st; tt2[1] = tr.cs; tv[1] = vl.vt;
				tk[2] = ka; tt1[2] = tr.ct; tt2[2] = tr.cs; tv[2] = vl.vr;
				tk[3] = kb; tt1[3] = tr.st; tv[3] = vl.vr;
			end
			default: ;
		endcase
	end

	for (genvar j = 0; j < 4; j++) begin : g_term
		scc_term u_term (
			.clk(clk), .en(en), .k(tk[j]), .t1(tt1[j]), .t2(tt2[j]), .v(tv[j]),
			.term(terms[j])
		);
	end

	scc_accum u_accum (
		.clk(clk), .en(en), .comp(comp_q), .kclip(kclip_s[TermStage]),
		.t0(terms[0]), .t1(terms[1]), .t2(terms[2]), .t3(terms[3]), .res(res)
	);

	assign from_skid = sv_q && (!ov_q || m_tready);
	assign from_pipe = !sv_q && v_s[LastStage] && (!ov_q || m_tready);
	assign to_skid   = !sv_q && v_s[LastStage] && ov_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else begin
			if (from_skid || from_pipe) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
			if (to_skid) sv_q <= 1'b1;
			else if (from_skid) sv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (from_skid) out_q <= skid_q;
		else if (from_pipe) out_q <= res;
		if (to_skid) skid_q <= res;
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = out_q.val;
	assign m_tuser  = out_q.clip;
endmodule

FILE: rtl/core/scc_cordic.sv
// Pipelined CORDIC sine and cosine of a turn-fraction angle, one iteration per stage
module scc_cordic (
	input  logic          clk,
	input  logic          en,
	input  scc_pkg::angle_t angle,
	output scc_pkg::data_t  sin_v,
	output scc_pkg::data_t  cos_v
);
	import scc_pkg::*;

	logic [31:0] turn;
	cord_t       x_s [CordicN];
	cord_t       y_s [CordicN];
	cord_t       z_s [CordicN];
	logic [1:0]  q_s [CordicN];
	cord_t       xc;
	cord_t       yc;

	assign turn = 32'(angle) << (32 - AngleW);

	for (genvar i = 0; i < CordicN; i++) begin : g_iter
		cord_t      xi;
		cord_t      yi;
		cord_t      zi;
		logic [1:0] qi;
		if (i == 0) begin : g_first
			assign xi = CordicGain;
			assign yi = '0;
			assign zi = cord_t'({4'd0, turn[29:0]});
			assign qi = turn[31:30];
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign qi = q_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[CordW-1]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - cord_t'({2'b00, AtanTurn[i]});
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + cord_t'({2'b00, AtanTurn[i]});
				end
				q_s[i] <= qi;
			end
		end
	end

	always_comb begin
		xc = x_s[CordicN-1];
		yc = y_s[CordicN-1];
		if (xc > TrigOneC) xc = TrigOneC;
		if (xc < -TrigOneC) xc = -TrigOneC;
		if (yc > TrigOneC) yc = TrigOneC;
		if (yc < -TrigOneC) yc = -TrigOneC;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (q_s[CordicN-1])
				2'd0: begin
					cos_v <= data_t'(xc);
					sin_v <= data_t'(yc);
				end
				2'd1: begin
					cos_v <= data_t'(-yc);
					sin_v <= data_t'(xc);
				end
				2'd2: begin
					cos_v <= data_t'(-xc);
					sin_v <= data_t'(-yc);
				end
				default: begin
					cos_v <= data_t'(yc);
					sin_v <= data_t'(-xc);
				end
			endcase
		end
	end
endmodule

FILE: rtl/core/scc_coeff.sv
// Precession and Coriolis coefficient stages: cA and cB from the tilt sine and cosine
module scc_coeff (
	input  logic           clk,
	input  logic           en,
	input  scc_pkg::data_t sa,
	input  scc_pkg::data_t ca,
	input  scc_pkg::data_t scale,
	input  scc_pkg::data_t cor,
	input  scc_pkg::data_t pre,
	output scc_pkg::data_t ka,
	output scc_pkg::data_t kb,
	output logic           kclip
);
	import scc_pkg::*;

	prod_t cp_s1;
	prod_t pc_s1;
	data_t sa_s1;
	rs_t   cp_s2;
	rs_t   pc_s2;
	data_t sa_s2;
	prod_t ka_s3;
	rs_t   cor_s3;
	logic  clip_s3;
	rs_t   ka_s4;
	prod_t kb_s4;
	logic  clip_s4;
	rs_t   kbr;

	assign kbr = round_sat(kb_s4, 1'b0);

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s1   <= scale * pre;
			pc_s1   <= pre * ca;
			sa_s1   <= sa;
			cp_s2   <= round_sat(cp_s1, 1'b0);
			pc_s2   <= round_sat(pc_s1, 1'b1);
			sa_s2   <= sa_s1;
			ka_s3   <= cp_s2.val * sa_s2;
			cor_s3  <= sat_sum(cor, pc_s2.val, 1'b0);
			clip_s3 <= cp_s2.clip | pc_s2.clip;
			ka_s4   <= round_sat(ka_s3, 1'b1);
			kb_s4   <= scale * cor_s3.val;
			clip_s4 <= clip_s3 | cor_s3.clip;
			ka      <= ka_s4.val;
			kb      <= kbr.val;
			kclip   <= clip_s4 | ka_s4.clip | kbr.clip;
		end
	end
endmodule

FILE: rtl/core/scc_term.sv
// One product lane: k times two trig factors times a velocity, rounded and clipped per step
module scc_term (
	input  logic           clk,
	input  logic           en,
	input  scc_pkg::data_t k,
	input  scc_pkg::data_t t1,
	input  scc_pkg::data_t t2,
	input  scc_pkg::data_t v,
	output scc_pkg::rs_t   term
);
	import scc_pkg::*;

	prod_t p_s1;
	data_t t2_s1;
	data_t v_s1;
	rs_t   r_s2;
	data_t t2_s2;
	data_t v_s2;
	prod_t p_s3;
	logic  c_s3;
	data_t v_s3;
	rs_t   r_s4;
	logic  c_s4;
	data_t v_s4;
	prod_t p_s5;
	logic  c_s5;
	rs_t   r_fin;

	assign r_fin = round_sat(p_s5, 1'b0);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1      <= k * t1;
			t2_s1     <= t2;
			v_s1      <= v;
			r_s2      <= round_sat(p_s1, 1'b1);
			t2_s2     <= t2_s1;
			v_s2      <= v_s1;
			p_s3      <= r_s2.val * t2_s2;
			c_s3      <= r_s2.clip;
			v_s3      <= v_s2;
			r_s4      <= round_sat(p_s3, 1'b1);
			c_s4      <= c_s3;
			v_s4      <= v_s3;
			p_s5      <= r_s4.val * v_s4;
			c_s5      <= c_s4 | r_s4.clip;
			term.val  <= r_fin.val;
			term.clip <= c_s5 | r_fin.clip;
		end
	end
endmodule

FILE: rtl/core/scc_accum.sv
// Saturating accumulation of up to four terms, one add per stage
module scc_accum (
	input  logic         clk,
	input  logic         en,
	input  logic [1:0]   comp,
	input  logic         kclip,
	input  scc_pkg::rs_t t0,
	input  scc_pkg::rs_t t1,
	input  scc_pkg::rs_t t2,
	input  scc_pkg::rs_t t3,
	output scc_pkg::rs_t res
);
	import scc_pkg::*;

	logic [3:0] sub;
	logic       kc;
	rs_t        a_s1;
	rs_t        a_s2;
	rs_t        a_s3;
	rs_t        t1_s1;
	rs_t        t2_s1;
	rs_t        t2_s2;
	rs_t        t3_s1;
	rs_t        t3_s2;
	rs_t        t3_s3;
	rs_t        m1;
	rs_t        m2;
	rs_t        m3;
	rs_t        m4;

	always_comb begin
		unique case (comp)
			COMP_RADIAL: begin
				sub = 4'b0010;
				kc  = kclip;
			end
			COMP_COLAT: begin
				sub = 4'b0111;
				kc  = kclip;
			end
			COMP_LONG: begin
				sub = 4'b0100;
				kc  = kclip;
			end
			default: begin
				sub = 4'b0000;
				kc  = 1'b0;
			end
		endcase
	end

	assign m1 = sat_sum('0, t0.val, sub[0]);
	assign m2 = sat_sum(a_s1.val, t1_s1.val, sub[1]);
	assign m3 = sat_sum(a_s2.val, t2_s2.val, sub[2]);
	assign m4 = sat_sum(a_s3.val, t3_s3.val, sub[3]);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1.val  <= m1.val;
			a_s1.clip <= kc | t0.clip | m1.clip;
			t1_s1     <= t1;
			t2_s1     <= t2;
			t3_s1     <= t3;
			a_s2.val  <= m2.val;
			a_s2.clip <= a_s1.clip | t1_s1.clip | m2.clip;
			t2_s2     <= t2_s1;
			t3_s2     <= t3_s1;
			a_s3.val  <= m3.val;
			a_s3.clip <= a_s2.clip | t2_s2.clip | m3.clip;
			t3_s3     <= t3_s2;
			res.val   <= m4.val;
			res.clip  <= a_s3.clip | t3_s3.clip | m4.clip;
		end
	end
endmodule

FILE: rtl/core/scc_checker.sv
// Port-level checks on the handshakes of the Coriolis precession term block
module scc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [scc_pkg::DataW-1:0] m_tdata,
	input logic                      m_tuser
);
	import scc_pkg::*;

	a_ready_low_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	a_ready_recovers: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && m_tready |=> s_tready)
		else $error("input stayed stalled after a result transfer");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before transfer");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");
endmodule

bind spherical_coriolis_precession_term scc_checker u_scc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

FILE: tb/sv/scc_term_checker.sv
// Checker for the Coriolis precession term: predicts each result and compares the output stream
`timescale 1ns / 100ps
module scc_term_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [scc_pkg::InW-1:0]       s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [scc_pkg::DataW-1:0]     m_tdata,
	input  logic                          m_tuser,
	input  logic                          cfg_we,
	input  logic [scc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [scc_pkg::DataW-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending
);
	import scc_pkg::*;

	localparam longint TrigUnit = 64'sd1073741824;
	localparam longint Gain     = 64'sd652032874;
	localparam longint PosLim   = 64'sd2147483647;
	localparam longint NegLim   = -64'sd2147483648;

	typedef struct {
		logic [DataW-1:0] force_val;
		logic             clipped;
	} term_t;

	logic [1:0]      comp_q;
	longint          scale_q, cor_q, pre_q;
	logic [AngleW-1:0] tilt_q, phase_q;
	term_t           term_q[$];
	bit              clipped_any;

	assign pending = term_q.size();

	function automatic longint shr_floor(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clip_mag(bit neg, logic [127:0] mag);
		if (!neg) begin
			if (mag > 128'(PosLim)) begin
				clipped_any = 1;
				return PosLim;
			end
			return longint'(mag);
		end
		if (mag > 128'd2147483648) begin
			clipped_any = 1;
			return NegLim;
		end
		return -longint'(mag);
	endfunction

	function automatic longint scaled_product(longint a, longint b, int sh);
		bit           neg;
		logic [127:0] ua, ub, p;
		neg = (a < 0) != (b < 0);
		ua = a < 0 ? 128'(-a) : 128'(a);
		ub = b < 0 ? 128'(-b) : 128'(b);
		p = (ua * ub + (128'd1 << (sh - 1))) >> sh;
		return clip_mag(neg, p);
	endfunction

	function automatic longint clip_sum(longint a, longint b, bit sub);
		longint s;
		s = sub ? a - b : a + b;
		if (s > PosLim) begin
			clipped_any = 1;
			return PosLim;
		end
		if (s < NegLim) begin
			clipped_any = 1;
			return NegLim;
		end
		return s;
	endfunction

	function automatic void turn_trig(logic [AngleW-1:0] ang, output longint sn,
		output longint cs);
		logic [31:0] a;
		longint      x, y, z, dx, dy;
		a = {ang, {(32 - AngleW){1'b0}}};
		z = longint'(a[29:0]);
		x = Gain;
		y = 0;
		for (int i = 0; i < CordicN; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(AtanTurn[i]);
			end else begin
				x += dx; y -= dy; z += longint'(AtanTurn[i]);
			end
		end
		if (x > TrigUnit) x = TrigUnit;
		if (x < -TrigUnit) x = -TrigUnit;
		if (y > TrigUnit) y = TrigUnit;
		if (y < -TrigUnit) y = -TrigUnit;
		case (a[31:30])
			2'd0: begin cs = x;  sn = y;  end
			2'd1: begin cs = -y; sn = x;  end
			2'd2: begin cs = -x; sn = -y; end
			default: begin cs = y; sn = -x; end
		endcase
	endfunction

	function automatic term_t precession_term(logic [InW-1:0] d);
		longint sa, ca, st, ct, ss, cs, ka, kb, acc, vr, vt, vp;
		term_t  r;
		logic [AngleW-1:0] th, ph;
		th = d[AngleW-1:0];
		ph = d[2*AngleW-1:AngleW];
		vr = longint'(data_t'(d[2*AngleW +: DataW]));
		vt = longint'(data_t'(d[2*AngleW+DataW +: DataW]));
		vp = longint'(data_t'(d[2*AngleW+2*DataW +: DataW]));
		clipped_any = 0;
		turn_trig(tilt_q, sa, ca);
		turn_trig(th, st, ct);
		turn_trig(ph + phase_q, ss, cs);
		ka = scaled_product(scaled_product(scale_q, pre_q, 16), sa, 30);
		kb = scaled_product(scale_q, clip_sum(cor_q, scaled_product(pre_q, ca, 30), 0), 16);
		acc = 0;
		case (comp_q)
			COMP_RADIAL: begin
				acc = clip_sum(acc, scaled_product(scaled_product(scaled_product(ka, ct, 30),
					cs, 30), vp, 16), 0);
				acc = clip_sum(acc, scaled_product(scaled_product(kb, st, 30), vp, 16), 1);
				acc = clip_sum(acc, scaled_product(scaled_product(ka, ss, 30), vt, 16), 0);
			end
			COMP_COLAT: begin
				acc = clip_sum(acc, scaled_product(scaled_product(kb, ct, 30), vp, 16), 1);
				acc = clip_sum(acc, scaled_product(scaled_product(scaled_product(ka, st, 30),
					cs, 30), vp, 16), 1);
				acc = clip_sum(acc, scaled_product(scaled_product(ka, ss, 30), vr, 16), 1);
			end
			COMP_LONG: begin
				acc = clip_sum(acc, scaled_product(scaled_product(kb, ct, 30), vt, 16), 0);
				acc = clip_sum(acc, scaled_product(scaled_product(scaled_product(ka, st, 30),
					cs, 30), vt, 16), 0);
				acc = clip_sum(acc, scaled_product(scaled_product(scaled_product(ka, ct, 30),
					cs, 30), vr, 16), 1);
				acc = clip_sum(acc, scaled_product(scaled_product(kb, st, 30), vr, 16), 0);
			end
			default: begin
				acc = 0;
				clipped_any = 0;
			end
		endcase
		r.force_val = DataW'(acc);
		r.clipped = clipped_any;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		term_t e;
		if (!arst_n) begin
			comp_q <= COMP_RADIAL;
			scale_q <= 65536;
			cor_q <= 0;
			pre_q <= 0;
			tilt_q <= '0;
			phase_q <= '0;
			fail_count <= 0;
			term_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (term_q.size() == 0) begin
					report_mismatch("unexpected transfer", m_tdata, 0);
				end else begin
					e = term_q.pop_front();
					if (m_tdata !== e.force_val)
						report_mismatch("force_value", m_tdata, e.force_val);
					if (m_tuser !== e.clipped)
						report_mismatch("saturated", m_tuser, e.clipped);
				end
			end
			if (s_tvalid && s_tready)
				term_q.push_back(precession_term(s_tdata));
			if (cfg_we) begin
				case (cfg_index)
					REG_COMP:       comp_q <= cfg_data[1:0];
					REG_SCALE:      scale_q <= longint'(data_t'(cfg_data));
					REG_CORIOLIS:   cor_q <= longint'(data_t'(cfg_data));
					REG_PRECESSION: pre_q <= longint'(data_t'(cfg_data));
					REG_TILT:       tilt_q <= cfg_data[AngleW-1:0];
					REG_PHASE:      phase_q <= cfg_data[AngleW-1:0];
					default: ;
				endcase
			end
		end
	end
endmodule

FILE: tb/sv/spherical_coriolis_precession_term_tb.sv
// Testbench top: drives points and register settings into the Coriolis precession term block
`timescale 1ns / 100ps
module spherical_coriolis_precession_term_tb;
	import scc_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InW-1:0]      s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [DataW-1:0]    m_tdata;
	logic                m_tuser;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [DataW-1:0]    cfg_data;
	int                  fail_count;
	int                  pending;
	bit                  hold_rx;
	int                  burst_left;

	spherical_coriolis_precession_term uut (.*);

	scc_term_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx)
				m_tready <= 0;
			else if ($urandom_range(0, 3) == 0)
				m_tready <= 1'($urandom_range(0, 1));
			else
				m_tready <= 1;
		end
	end

	function automatic logic [31:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'hffffffff;
			4: return 32'h00010000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] q16_word();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return edge_word();
		if (r < 5)
			return $urandom;
		return 32'($signed($urandom_range(0, 32'h00080000)) - 32'sh00040000);
	endfunction

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_point(logic [InW-1:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic send_random(int n);
		logic [AngleW-1:0] th, ph;
		for (int i = 0; i < n; i++) begin
			th = AngleW'($urandom);
			ph = AngleW'($urandom);
			send_point({q16_word(), q16_word(), q16_word(), ph, th});
		end
	endtask

	task automatic set_regs(logic [1:0] comp, logic [31:0] sc, logic [31:0] co,
		logic [31:0] pr, logic [15:0] ti, logic [15:0] ph);
		write_reg(REG_COMP, 32'(comp));
		write_reg(REG_SCALE, sc);
		write_reg(REG_CORIOLIS, co);
		write_reg(REG_PRECESSION, pr);
		write_reg(REG_TILT, 32'(ti));
		write_reg(REG_PHASE, 32'(ph));
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		hold_rx = 0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n = 1;

		set_regs(COMP_RADIAL, 32'h00010000, 32'h00008000, 32'h00004000, 16'h2000, 16'hf000);
		send_point({32'h7fffffff, 32'h80000000, 32'h00010000, 16'hffff, 16'h0000});
		send_point({32'h80000000, 32'h7fffffff, 32'hffffffff, 16'h0000, 16'hffff});
		send_point({32'h00010000, 32'h00010000, 32'h00010000, 16'h4000, 16'h4000});
		send_point({32'h00010000, 32'h00010000, 32'h00010000, 16'h8000, 16'hc000});
		drain();
		for (int c = 0; c < 4; c++) begin
			set_regs(2'(c), 32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'hffff, 16'hffff);
			send_point({32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'h0001, 16'h2000});
			send_point({32'h00000000, 32'h00000000, 32'h00000000, 16'h1234, 16'h4321});
			send_point({32'h80000000, 32'h80000000, 32'h7fffffff, 16'hffff, 16'h8000});
			drain();
		end

		for (int ph = 0; ph < 12; ph++) begin
			if (ph % 3 == 2)
				set_regs(2'($urandom_range(0, 3)), edge_word(), edge_word(), edge_word(),
					16'($urandom), 16'($urandom));
			else
				set_regs(2'($urandom_range(0, 2)), q16_word(), q16_word(), q16_word(),
					16'($urandom), 16'($urandom));
			if (ph == 4) begin
				fork
					begin
						hold_rx = 1;
						repeat (150) @(posedge clk);
						hold_rx = 0;
					end
					send_random(50);
				join
			end else begin
				send_random(45);
			end
			drain();
		end

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

FILE: spherical_coriolis_precession_term.f
rtl/core/scc_pkg.sv
rtl/core/scc_cordic.sv
rtl/core/scc_coeff.sv
rtl/core/scc_term.sv
rtl/core/scc_accum.sv
rtl/core/spherical_coriolis_precession_term.sv
rtl/core/scc_checker.sv
tb/sv/scc_term_checker.sv
tb/sv/spherical_coriolis_precession_term_tb.sv
